>>> hw/rtl/slps_pkg.sv
`default_nettype none
package slps_pkg;

	localparam int FADE_STEPS = 32;
	localparam int FADE_W     = $clog2(FADE_STEPS + 1);
	localparam int FADE_SHIFT = $clog2(FADE_STEPS);
	localparam int STEP_SHIFT = $clog2(2 * FADE_STEPS);
	localparam int STEP_W     = 16 - STEP_SHIFT;
	localparam int STATE_CNT  = 7;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_STATE = 2'd1;
	localparam logic [1:0] ACT_LOAD  = 2'd2;

	localparam logic [4:0] LAST_NONE = 5'd16;

	typedef enum logic [1:0] {
		EFF_OFF   = 2'd0,
		EFF_SOLID = 2'd1,
		EFF_BLINK = 2'd2,
		EFF_PULSE = 2'd3
	} effect_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  app_state;
		logic [7:0]  pat_red;
		logic [7:0]  pat_green;
		logic [7:0]  pat_blue;
		logic [1:0]  pat_effect;
		logic [15:0] pat_on_ms;
		logic [15:0] pat_off_ms;
		logic [15:0] pat_period_ms;
	} slps_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} slps_out_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		effect_t     eff;
		logic [15:0] on_ms;
		logic [15:0] off_ms;
		logic [15:0] fade_period;
	} pattern_t;

	function automatic pattern_t state_pattern(input logic [3:0] st);
		pattern_t p;
		p = '{8'd0, 8'd0, 8'd0, EFF_OFF, 16'd0, 16'd0, 16'd0};
		case (st)
			4'd0:    p = '{8'd20, 8'd20, 8'd20, EFF_PULSE, 16'd0, 16'd0, 16'd1500};
			4'd1:    p = '{8'd0, 8'd30, 8'd0, EFF_SOLID, 16'd0, 16'd0, 16'd0};
			4'd2:    p = '{8'd0, 8'd0, 8'd50, EFF_BLINK, 16'd800, 16'd400, 16'd0};
			4'd3:    p = '{8'd0, 8'd60, 8'd0, EFF_BLINK, 16'd150, 16'd150, 16'd0};
			4'd4:    p = '{8'd0, 8'd50, 8'd0, EFF_SOLID, 16'd0, 16'd0, 16'd0};
			4'd5:    p = '{8'd0, 8'd40, 8'd40, EFF_BLINK, 16'd100, 16'd100, 16'd0};
			4'd6:    p = '{8'd60, 8'd0, 8'd0, EFF_BLINK, 16'd200, 16'd200, 16'd0};
			default: p = '{8'd0, 8'd0, 8'd0, EFF_OFF, 16'd0, 16'd0, 16'd0};
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/slps_scale.sv
`default_nettype none
module slps_scale
	import slps_pkg::*;
(
	input  wire logic [7:0]        level,
	input  wire logic [FADE_W-1:0] fade,
	output logic      [7:0]        scaled
);

	logic [8+FADE_W-1:0] prod;

	always_comb begin
		prod   = {{FADE_W{1'b0}}, level} * {8'd0, fade};
		scaled = prod[FADE_SHIFT +: 8];
	end

endmodule
`default_nettype wire

>>> hw/rtl/slps_core.sv
`default_nettype none
module slps_core
	import slps_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire slps_in_t  req,
	output slps_out_t      color
);

	logic [7:0]        red_q, green_q, blue_q;
	effect_t           eff_q;
	logic [15:0]       on_q, off_q;
	logic [STEP_W-1:0] step_q;
	logic [15:0]       ms_q;
	logic [FADE_W-1:0] fade_q;
	logic              phase_q;
	logic [4:0]        last_q;

	logic [7:0]        red_d, green_d, blue_d;
	effect_t           eff_d;
	logic [15:0]       on_d, off_d;
	logic [STEP_W-1:0] step_d;
	logic [15:0]       ms_d;
	logic [FADE_W-1:0] fade_d;
	logic              phase_d;
	logic [4:0]        last_d;

	pattern_t          pat;
	logic              do_load;
	logic [15:0]       len;
	logic [15:0]       nlen;
	logic [16:0]       cnt1;
	logic [STEP_W-1:0] st_raw;
	logic [7:0]        sc_red, sc_green, sc_blue;

	always_comb begin
		red_d   = red_q;
		green_d = green_q;
		blue_d  = blue_q;
		eff_d   = eff_q;
		on_d    = on_q;
		off_d   = off_q;
		step_d  = step_q;
		ms_d    = ms_q;
		fade_d  = fade_q;
		phase_d = phase_q;
		last_d  = last_q;
		do_load = 1'b0;
		pat     = state_pattern(req.app_state);
		len     = phase_q ? off_q : on_q;
		nlen    = phase_q ? on_q : off_q;
		cnt1    = {1'b0, ms_q} + 17'd1;
		st_raw  = '0;

		case (req.action)
			ACT_TICK: begin
				if (eff_q == EFF_BLINK) begin
					if (len != 16'd0) begin
						if (cnt1 >= {1'b0, len}) begin
							ms_d = '0;
							if (nlen != 16'd0)
								phase_d = ~phase_q;
						end else begin
							ms_d = cnt1[15:0];
						end
					end
				end else if (eff_q == EFF_PULSE) begin
					if (cnt1 >= {{(17-STEP_W){1'b0}}, step_q}) begin
						ms_d = '0;
						if (!phase_q) begin
							if (fade_q < FADE_W'(FADE_STEPS))
								fade_d = fade_q + FADE_W'(1);
							else
								phase_d = 1'b1;
						end else begin
							if (fade_q != '0)
								fade_d = fade_q - FADE_W'(1);
							else
								phase_d = 1'b0;
						end
					end else begin
						ms_d = cnt1[15:0];
					end
				end
			end
			ACT_STATE: begin
				if ({1'b0, req.app_state} != last_q) begin
					last_d  = {1'b0, req.app_state};
					do_load = 1'b1;
				end
			end
			ACT_LOAD: begin
				pat     = '{req.pat_red, req.pat_green, req.pat_blue,
					effect_t'(req.pat_effect), req.pat_on_ms, req.pat_off_ms,
					req.pat_period_ms};
				do_load = 1'b1;
			end
			default: ;
		endcase

		if (do_load) begin
			red_d   = pat.red;
			green_d = pat.green;
			blue_d  = pat.blue;
			eff_d   = pat.eff;
			on_d    = pat.on_ms;
			off_d   = pat.off_ms;
			st_raw  = pat.fade_period[15:STEP_SHIFT];
			step_d  = (st_raw == '0) ? STEP_W'(1) : st_raw;
			ms_d    = '0;
			fade_d  = '0;
			// start in the off phase when the on phase is empty
			phase_d = (pat.eff == EFF_BLINK) && (pat.on_ms == 16'd0);
		end
	end

	slps_scale u_scale_r (.level(red_d),   .fade(fade_d), .scaled(sc_red));
	slps_scale u_scale_g (.level(green_d), .fade(fade_d), .scaled(sc_green));
	slps_scale u_scale_b (.level(blue_d),  .fade(fade_d), .scaled(sc_blue));

	always_comb begin
		color = '0;
		if (eff_d == EFF_SOLID || (eff_d == EFF_BLINK && !phase_d))
			color = '{red_d, green_d, blue_d};
		else if (eff_d == EFF_PULSE)
			color = '{sc_red, sc_green, sc_blue};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			eff_q   <= EFF_OFF;
			on_q    <= '0;
			off_q   <= '0;
			step_q  <= STEP_W'(1);
			ms_q    <= '0;
			fade_q  <= '0;
			phase_q <= 1'b0;
			last_q  <= LAST_NONE;
		end else if (en) begin
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
			eff_q   <= eff_d;
			on_q    <= on_d;
			off_q   <= off_d;
			step_q  <= step_d;
			ms_q    <= ms_d;
			fade_q  <= fade_d;
			phase_q <= phase_d;
			last_q  <= last_d;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/status_led_pattern_sequencer_top.sv
`default_nettype none
// channel | valid     | stall     | payload
// request | req_valid | req_stall | req (slps_in_t)
// led     | led_valid | led_stall | led (slps_out_t)
//
// Each request is registered, then updated against the pattern state and the
// resulting color is registered into led.
// One request per cycle is taken while led is not stalled; the pattern state update is the only loop.
// Reset clears the pattern to off and marks no application state seen.
// A stall on led holds the result and backs up into req_stall in the same cycle.
module status_led_pattern_sequencer_top
	import slps_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire slps_in_t  req,
	output logic           led_valid,
	input  wire logic      led_stall,
	output slps_out_t      led
);

	logic      s1_valid;
	slps_in_t  req_s1;
	logic      led_ready;
	logic      advance;
	slps_out_t color;

	assign led_ready = !led_valid || !led_stall;
	assign advance   = s1_valid && led_ready;
	assign req_stall = s1_valid && !led_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!req_stall) begin
			s1_valid <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			req_s1 <= req;
	end

	slps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.req    (req_s1),
		.color  (color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_valid <= 1'b0;
		end else if (led_ready) begin
			led_valid <= advance;
		end
	end

	// hold the result until it is taken
	always_ff @(posedge clk) begin
		if (advance)
			led <= color;
	end

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> s1_valid)
		else $error("request stalled with empty input stage");

	a_empty_out_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!led_valid |-> !req_stall)
		else $error("request stalled while result register is empty");

	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> led_valid)
		else $error("advanced request produced no result");

	a_blocked_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !led_ready) |=> (s1_valid && $stable(req_s1)))
		else $error("blocked input stage lost its request");

endmodule
`default_nettype wire
